>>> design/esp_pkg.sv
// Package for the escape scope stream parser.
// Scope codes, stack control struct, status codes and byte constants.
// No dependencies.
package esp_pkg;

  localparam int STACK_DEPTH_DEF = 4;

  typedef enum logic [2:0] {
    SC_NONE   = 3'd0,
    SC_FILE   = 3'd1,
    SC_GROUP  = 3'd2,
    SC_RECORD = 3'd3,
    SC_UNIT   = 3'd4,
    SC_QUOTED = 3'd5
  } scope_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

  localparam logic [1:0] ST_SILENT = 2'd0;
  localparam logic [1:0] ST_EMIT   = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

  localparam logic [7:0] BYTE_ESC = 8'h1B;
  localparam logic [7:0] BYTE_FS  = 8'h1C;
  localparam logic [7:0] BYTE_GS  = 8'h1D;
  localparam logic [7:0] BYTE_RS  = 8'h1E;
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] CHAR_F   = 8'h46;
  localparam logic [7:0] CHAR_G   = 8'h47;
  localparam logic [7:0] CHAR_R   = 8'h52;
  localparam logic [7:0] CHAR_U   = 8'h55;
  localparam logic [7:0] CHAR_Q   = 8'h51;

endpackage

>>> design/esp_in_if.sv
// Input channel of the escape scope stream parser: one raw byte per transfer.
// Valid/ready handshake; no dependencies.
interface esp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

>>> design/esp_out_if.sv
// Result channel of the escape scope stream parser: one result per transfer.
// Valid/ready handshake; no dependencies.
interface esp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] data_out;
  logic       well_formed;
  logic [1:0] mode_now;
  logic [2:0] open_scopes;

  modport source (output valid, output status, output data_out, output well_formed,
                  output mode_now, output open_scopes, input ready);
  modport sink   (input valid, input status, input data_out, input well_formed,
                  input mode_now, input open_scopes, output ready);
endinterface

>>> design/esp_scope_cell.sv
// One entry of the scope stack, built as a shift chain with cell 0 on top.
// Push takes the code from the cell above, pop from the cell below.
// Depends on esp_pkg.
module esp_scope_cell
  import esp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  stack_op_t op,
  input  scope_t    from_above,
  input  scope_t    from_below,
  output scope_t    code
);

  scope_t code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= SC_NONE;
    end else if (op.push) begin
      code_r <= from_above;
    end else if (op.pop) begin
      code_r <= from_below;
    end
  end

  assign code = code_r;

endmodule

>>> design/escape_scope_stream_parser.sv
// Escape scope stream parser: four-mode byte parser over a chain of scope cells.
// The result appears in the output register in the cycle after the input transfer.
// Throughput: 1 byte per cycle, no output stall; mode/top-of-stack decision combinational.
// Reset (synchronous, rst_n low): data mode, empty stack, all cells none, no result pending.
// Depends on esp_pkg, esp_in_if, esp_out_if, esp_scope_cell.
module escape_scope_stream_parser
  import esp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic clk,
  input logic rst_n,
  esp_in_if.sink    in_if,
  esp_out_if.source out_if
);

  localparam int DW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_DATA  = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_CTRL  = 2'd2,
    MODE_QUOTE = 2'd3
  } mode_t;

  mode_t          mode_r, mode_nxt;
  logic [DW-1:0]  depth_r, depth_nxt;
  scope_t         cell_q [STACK_DEPTH];
  scope_t         push_code;
  stack_op_t      op;
  logic           in_fire;
  logic           full, empty;
  scope_t         top;
  logic [7:0]     b, b_up;
  logic [1:0]     status_nxt;
  logic [7:0]     data_nxt;
  logic           wf_nxt;
  logic           do_push, do_pop;

  logic           out_valid_r;
  logic [1:0]     status_r;
  logic [7:0]     data_r;
  logic           wf_r;
  logic [1:0]     mode_out_r;
  logic [2:0]     open_r;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  assign b     = in_if.byte_in;
  assign b_up  = b & ~CASE_BIT;
  assign full  = depth_r == DW'(STACK_DEPTH);
  assign empty = depth_r == '0;
  assign top   = cell_q[0];

  always_comb begin
    mode_nxt   = mode_r;
    status_nxt = ST_SILENT;
    data_nxt   = 8'h00;
    push_code  = SC_NONE;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    unique case (mode_r)
      MODE_DATA: begin
        if (b == BYTE_ESC) begin
          mode_nxt = MODE_ESC;
        end else begin
          status_nxt = ST_EMIT;
          data_nxt   = b;
        end
      end
      MODE_ESC: begin
        if (b == BYTE_ESC) begin
          status_nxt = ST_EMIT;
          data_nxt   = BYTE_ESC;
          mode_nxt   = MODE_DATA;
        end else begin
          unique case (b_up)
            CHAR_F: begin
              push_code = SC_FILE;
              do_push   = 1'b1;
              mode_nxt  = MODE_CTRL;
            end
            CHAR_G: begin
              push_code = SC_GROUP;
              do_push   = 1'b1;
              mode_nxt  = MODE_CTRL;
            end
            CHAR_R: begin
              push_code = SC_RECORD;
              do_push   = 1'b1;
              mode_nxt  = MODE_CTRL;
            end
            CHAR_U: begin
              push_code = SC_UNIT;
              do_push   = 1'b1;
              mode_nxt  = MODE_CTRL;
            end
            CHAR_Q: begin
              push_code = SC_QUOTED;
              do_push   = 1'b1;
              mode_nxt  = MODE_QUOTE;
            end
            default: status_nxt = ST_ERROR;
          endcase
        end
      end
      MODE_CTRL: begin
        if (empty) begin
          mode_nxt = MODE_DATA;
        end else begin
          case (top)
            SC_UNIT:   do_pop = 1'b1;
            SC_FILE:   do_pop = (b == BYTE_FS);
            SC_GROUP:  do_pop = (b == BYTE_GS);
            SC_RECORD: do_pop = (b == BYTE_RS);
            default:   status_nxt = ST_ERROR;
          endcase
          if (do_pop && depth_r == DW'(1)) begin
            mode_nxt = MODE_DATA;
          end
        end
      end
      MODE_QUOTE: begin
        if (empty) begin
          mode_nxt = MODE_DATA;
        end else if (top == SC_QUOTED && b == BYTE_ESC) begin
          mode_nxt = MODE_ESC;
        end else begin
          status_nxt = ST_EMIT;
          data_nxt   = b;
        end
      end
      default: mode_nxt = MODE_DATA;
    endcase

    op.push   = in_fire && do_push && !full;
    op.pop    = in_fire && do_pop;
    depth_nxt = depth_r;
    if (do_push && !full) begin
      depth_nxt = depth_r + DW'(1);
    end else if (do_pop) begin
      depth_nxt = depth_r - DW'(1);
    end

    wf_nxt = !(mode_nxt == MODE_ESC || (mode_nxt == MODE_DATA && depth_nxt != '0));
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    scope_t above, below;
    if (i == 0) begin : g_top
      assign above = push_code;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = SC_NONE;
    end else begin : g_low
      assign below = cell_q[i+1];
    end
    esp_scope_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .from_above (above),
      .from_below (below),
      .code       (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_DATA;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_r      <= mode_nxt;
        depth_r     <= depth_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r   <= status_nxt;
      data_r     <= data_nxt;
      wf_r       <= wf_nxt;
      mode_out_r <= mode_nxt;
      open_r     <= 3'(32'(depth_nxt));
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = status_r;
  assign out_if.data_out    = data_r;
  assign out_if.well_formed = wf_r;
  assign out_if.mode_now    = mode_out_r;
  assign out_if.open_scopes = open_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH))
    else $error("scope depth beyond stack size");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r == '0 |-> cell_q[0] == SC_NONE)
    else $error("empty stack holds a top scope");

  a_ctrl_open: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_CTRL |-> depth_r != '0)
    else $error("control mode with no open scope");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted byte produced no result");

endmodule

>>> test/escape_scope_stream_parser_tb.sv
`timescale 1ns / 1ps
// Testbench for escape_scope_stream_parser: byte stimulus with random idles and stalls.
// An in-bench parser model predicts every result; depends on esp_pkg, esp_in_if, esp_out_if.
module escape_scope_stream_parser_tb;
  import esp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SW          = $clog2(STACK_DEPTH_DEF);

  typedef enum logic [1:0] {
    MODE_DATA  = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_CTRL  = 2'd2,
    MODE_QUOTE = 2'd3
  } parse_mode_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic       wf;
    logic [1:0] mode;
    logic [2:0] scopes;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n;

  esp_in_if  in_ch ();
  esp_out_if out_ch ();

  escape_scope_stream_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  parse_mode_t   cur_mode = MODE_DATA;
  int unsigned   scope_cnt = 0;
  scope_t        scope_stk [STACK_DEPTH_DEF] = '{default: SC_NONE};
  parse_result_t exp_q [$];
  int            err_cnt = 0;
  int            sent_cnt = 0;
  int            cycle_cnt = 0;
  bit            tx_idle = 1'b0;
  bit            rx_idle = 1'b0;
  int            rx_hold = 0;

  initial forever #4 clk = ~clk;

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic scope_t letter_scope(input logic [7:0] b);
    case (b | CASE_BIT)
      CHAR_F | CASE_BIT: return SC_FILE;
      CHAR_G | CASE_BIT: return SC_GROUP;
      CHAR_R | CASE_BIT: return SC_RECORD;
      CHAR_U | CASE_BIT: return SC_UNIT;
      CHAR_Q | CASE_BIT: return SC_QUOTED;
      default:           return SC_NONE;
    endcase
  endfunction

  // Advances the parser model by one byte and returns the result it implies.
  function automatic parse_result_t parse_byte(input logic [7:0] b);
    parse_result_t r;
    scope_t        top;
    scope_t        sc;
    r   = '0;
    top = (scope_cnt == 0) ? SC_NONE : scope_stk[SW'(scope_cnt - 1)];
    sc  = letter_scope(b);
    case (cur_mode)
      MODE_DATA: begin
        if (b == BYTE_ESC) begin
          cur_mode = MODE_ESC;
        end else begin
          r.status = ST_EMIT;
          r.data   = b;
        end
      end
      MODE_ESC: begin
        if (b == BYTE_ESC) begin
          r.status = ST_EMIT;
          r.data   = BYTE_ESC;
          cur_mode = MODE_DATA;
        end else if (sc == SC_NONE) begin
          r.status = ST_ERROR;
        end else begin
          if (scope_cnt < STACK_DEPTH_DEF) begin
            scope_stk[SW'(scope_cnt)] = sc;
            scope_cnt++;
          end
          cur_mode = (sc == SC_QUOTED) ? MODE_QUOTE : MODE_CTRL;
        end
      end
      MODE_CTRL: begin
        if (scope_cnt == 0) begin
          cur_mode = MODE_DATA;
        end else if (top == SC_QUOTED) begin
          r.status = ST_ERROR;
        end else if (top == SC_UNIT || (top == SC_FILE && b == BYTE_FS) ||
                     (top == SC_GROUP && b == BYTE_GS) || (top == SC_RECORD && b == BYTE_RS)) begin
          scope_cnt--;
          scope_stk[SW'(scope_cnt)] = SC_NONE;
          if (scope_cnt == 0) cur_mode = MODE_DATA;
        end
      end
      default: begin
        if (scope_cnt == 0) begin
          cur_mode = MODE_DATA;
        end else if (top == SC_QUOTED && b == BYTE_ESC) begin
          cur_mode = MODE_ESC;
        end else begin
          r.status = ST_EMIT;
          r.data   = b;
        end
      end
    endcase
    r.wf     = !(cur_mode == MODE_ESC || (scope_cnt > 0 && cur_mode == MODE_DATA));
    r.mode   = cur_mode;
    r.scopes = scope_cnt[2:0];
    return r;
  endfunction

  function automatic logic [7:0] random_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 8))
        0: b = BYTE_ESC;
        1: b = BYTE_FS;
        2: b = BYTE_GS;
        3: b = BYTE_RS;
        4: b = CHAR_F;
        5: b = CHAR_G;
        6: b = CHAR_R;
        7: b = CHAR_U;
        default: b = CHAR_Q;
      endcase
      if (b > BYTE_RS && $urandom_range(0, 1) == 1) b = b | CASE_BIT;
    end
    return b;
  endfunction

  function automatic logic [7:0] bad_letter();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == BYTE_ESC || letter_scope(b) != SC_NONE) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.byte_in <= b;
    do @(posedge clk); while (!in_ch.ready);
    exp_q.push_back(parse_byte(b));
    sent_cnt++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string field, input logic [7:0] want, input logic [7:0] got);
    err_cnt++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endtask

  // Result sink: random stalls per transfer plus an optional long hold-off.
  initial begin : result_sink
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold != 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      gap = rx_idle ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin : check_result
    parse_result_t want;
    parse_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{status: out_ch.status, data: out_ch.data_out, wf: out_ch.well_formed,
              mode: out_ch.mode_now, scopes: out_ch.open_scopes};
      if (exp_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, got %0h", $time, got);
      end else begin
        want = exp_q.pop_front();
        if (got.status !== want.status)
          note_mismatch("status", 8'(want.status), 8'(got.status));
        if (got.data !== want.data) note_mismatch("data_out", want.data, got.data);
        if (got.wf !== want.wf) note_mismatch("well_formed", 8'(want.wf), 8'(got.wf));
        if (got.mode !== want.mode) note_mismatch("mode_now", 8'(want.mode), 8'(got.mode));
        if (got.scopes !== want.scopes)
          note_mismatch("open_scopes", 8'(want.scopes), 8'(got.scopes));
      end
    end
  end

  // One piece of stimulus that never opens a quoted scope.
  task automatic scope_stim_step();
    logic [7:0] b;
    logic [7:0] letter;
    logic [7:0] close;
    int         pick;
    int         n;
    pick = $urandom_range(0, 99);
    if (cur_mode != MODE_DATA || pick < 25) begin
      b = random_byte();
      if (cur_mode == MODE_ESC && letter_scope(b) == SC_QUOTED) b = BYTE_ESC;
      send_byte(b);
    end else if (pick < 38) begin
      send_byte(BYTE_ESC);
      send_byte(BYTE_ESC);
    end else if (pick < 48) begin
      send_byte(BYTE_ESC);
      repeat ($urandom_range(1, 3)) send_byte(bad_letter());
      send_byte(BYTE_ESC);
    end else begin
      case ($urandom_range(0, 3))
        0: begin letter = CHAR_F; close = BYTE_FS; end
        1: begin letter = CHAR_G; close = BYTE_GS; end
        2: begin letter = CHAR_R; close = BYTE_RS; end
        default: begin letter = CHAR_U; close = 8'h00; end
      endcase
      if ($urandom_range(0, 1) == 1) letter = letter | CASE_BIT;
      send_byte(BYTE_ESC);
      send_byte(letter);
      if ((letter | CASE_BIT) == (CHAR_U | CASE_BIT)) begin
        send_byte(random_byte());
      end else begin
        n = $urandom_range(0, 4);
        repeat (n) begin
          b = random_byte();
          while (b == close) b = 8'($urandom_range(0, 255));
          send_byte(b);
        end
        send_byte(close);
      end
    end
  endtask

  task automatic test_data_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(BYTE_FS);
  endtask

  task automatic test_escapes();
    send_byte(BYTE_ESC);
    send_byte(BYTE_ESC);
    send_byte(BYTE_ESC);
    send_byte(8'h78);
    send_byte(BYTE_ESC);
  endtask

  task automatic test_scopes();
    send_byte(BYTE_ESC);
    send_byte(CHAR_F);
    send_byte(BYTE_GS);
    send_byte(BYTE_FS);
    send_byte(BYTE_ESC);
    send_byte(CHAR_G | CASE_BIT);
    send_byte(BYTE_GS);
    send_byte(BYTE_ESC);
    send_byte(CHAR_R);
    send_byte(8'hFF);
    send_byte(BYTE_RS);
    send_byte(BYTE_ESC);
    send_byte(CHAR_U | CASE_BIT);
    send_byte(BYTE_ESC);
  endtask

  task automatic test_random_scopes(input int count);
    int stop_at;
    int next_swap;
    stop_at   = sent_cnt + count;
    next_swap = sent_cnt;
    while (sent_cnt < stop_at) begin
      if (sent_cnt >= next_swap) begin
        tx_idle   = ($urandom_range(0, 2) != 0);
        rx_idle   = ($urandom_range(0, 2) != 0);
        next_swap = sent_cnt + 50;
      end
      scope_stim_step();
    end
  endtask

  // Sink holds off while the source keeps offering, so the input side stalls.
  task automatic test_backpressure();
    int stop_at;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 80;
    stop_at = sent_cnt + 40;
    while (sent_cnt < stop_at) scope_stim_step();
  endtask

  // Quoted scopes are never closed: control mode over one only flags errors and sticks,
  // so from here on the stack fills with quoted scopes and stays full.
  task automatic test_quoted();
    send_byte(BYTE_ESC);
    send_byte(CHAR_Q);
    send_byte(8'h41);
    send_byte(BYTE_FS);
    send_byte(BYTE_ESC);
    send_byte(BYTE_ESC);
    send_byte(8'h20);
    send_byte(BYTE_ESC);
    send_byte(CHAR_Q | CASE_BIT);
    send_byte(BYTE_ESC);
    send_byte(CHAR_Q);
    send_byte(BYTE_ESC);
    send_byte(CHAR_Q);
    send_byte(BYTE_ESC);
    send_byte(CHAR_Q | CASE_BIT);
    send_byte(8'h7F);
    send_byte(BYTE_ESC);
    send_byte(8'h7A);
    send_byte(BYTE_ESC);
  endtask

  task automatic test_random_quoted(input int count);
    int         stop_at;
    int         pick;
    logic [7:0] b;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    stop_at = sent_cnt + count;
    while (sent_cnt < stop_at) begin
      pick = $urandom_range(0, 99);
      if (cur_mode == MODE_ESC) begin
        if (pick < 35) b = BYTE_ESC;
        else if (pick < 60) b = ($urandom_range(0, 1) == 1) ? (CHAR_Q | CASE_BIT) : CHAR_Q;
        else b = bad_letter();
      end else begin
        b = (pick < 20) ? BYTE_ESC : 8'($urandom_range(0, 255));
      end
      send_byte(b);
    end
  endtask

  // A control letter onto the full quoted stack leaves control mode over a quoted scope.
  task automatic test_control_over_quoted();
    logic [7:0] letter;
    case ($urandom_range(0, 3))
      0: letter = CHAR_F;
      1: letter = CHAR_G;
      2: letter = CHAR_R;
      default: letter = CHAR_U;
    endcase
    if (cur_mode != MODE_ESC) send_byte(BYTE_ESC);
    send_byte(letter);
    repeat (20) send_byte(random_byte());
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.byte_in <= 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_data_bytes();
    test_escapes();
    test_scopes();
    wait_drained();
    test_random_scopes(200);
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random_scopes(200);
    wait_drained();
    test_quoted();
    test_random_quoted(60);
    wait_drained();
    test_control_over_quoted();
    wait_drained();
    repeat (4) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
design/esp_pkg.sv
design/esp_in_if.sv
design/esp_out_if.sv
design/esp_scope_cell.sv
design/escape_scope_stream_parser.sv
test/escape_scope_stream_parser_tb.sv
